// ===== rtl/blte_pkg.sv =====
// Shared types and constants for the bilinear lookup tree evaluator.
package blte_pkg;
  localparam int Dim        = 4;
  localparam int MaxRes     = 16;
  localparam int FracBits   = 12;
  localparam int TreeWidth  = (Dim <= 2) ? 2 : ((Dim <= 4) ? 4 : 8);
  localparam int NumUnits   = TreeWidth - 1;
  localparam int NumLayers  = $clog2(TreeWidth);
  localparam int UnitWords  = MaxRes * MaxRes;
  localparam int TableWords = NumUnits * UnitWords;
  localparam int ResBits    = $clog2(MaxRes);
  localparam int AddrBits   = 2 * ResBits;
  localparam int IdxBits    = 11;
  localparam int NumIn      = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef logic signed [15:0] val_t;

  // one table write, broadcast to every lane
  typedef struct packed {
    logic                en;
    logic [IdxBits-1:0]  idx;
    val_t                data;
  } wr_t;

  // per-stage item tag; the write rides along so each layer applies it in order
  typedef struct packed {
    logic vld;
    logic eval;
    logic sat;
    wr_t  wr;
  } tag_t;
endpackage

// ===== rtl/blte_unit.sv =====
// One lookup unit: 4-bank weight grid and a pipelined bilinear interpolator.
module blte_unit
  import blte_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [IdxBits-1:0]      base,
  input  wr_t                     wr,
  input  logic [4:0]              r1,
  input  val_t                    xv,
  input  val_t                    yv,
  output val_t                    res,
  output logic                    sat
);
  localparam int PBits = 16 + 5;
  localparam int QBits = AddrBits - 2;

  // four banks by (x parity, y parity); each corner hits a different bank
  val_t bank0 [UnitWords/4];
  val_t bank1 [UnitWords/4];
  val_t bank2 [UnitWords/4];
  val_t bank3 [UnitWords/4];

  logic [ResBits-1:0] wx, wy;
  logic [QBits-1:0]   waddr;
  logic               wsel;
  assign wx    = wr.idx[AddrBits-1:ResBits];
  assign wy    = wr.idx[ResBits-1:0];
  assign waddr = {wx[ResBits-1:1], wy[ResBits-1:1]};
  assign wsel  = en && wr.en && (wr.idx >= base)
                 && (wr.idx < base + IdxBits'(UnitWords));

  // stage 1: scale
  logic signed [PBits-1:0] px, py;
  logic signed [PBits-1:0] px_s1, py_s1;
  assign px = PBits'(xv) * $signed({1'b0, r1});
  assign py = PBits'(yv) * $signed({1'b0, r1});
  always_ff @(posedge clk) begin
    if (en) begin
      px_s1 <= px;
      py_s1 <= py;
    end
  end

  function automatic logic [ResBits-1:0] cell_idx(input logic signed [PBits-1:0] p,
                                                  input logic [4:0] lim);
    logic signed [PBits-FracBits-1:0] b;
    logic [4:0] l;
    b = p[PBits-1:FracBits];
    l = lim - 5'd1;
    if (p < 0) return '0;
    if (b > $signed({1'b0, l})) return ResBits'(l);
    return ResBits'(b[ResBits-1:0]);
  endfunction

  // stage 2: cell, distances, bank reads
  logic [ResBits-1:0] xb, yb, xb1, yb1;
  logic signed [PBits:0] xdl, xdu, ydl, ydu;
  logic signed [PBits:0] xdl_s2, xdu_s2, ydl_s2, ydu_s2;
  logic [QBits-1:0] a0, a1, a2, a3;
  logic [1:0] par_s2;
  val_t q0, q1, q2, q3;
  assign xb  = cell_idx(px_s1, r1);
  assign yb  = cell_idx(py_s1, r1);
  assign xb1 = xb + 1'b1;
  assign yb1 = yb + 1'b1;
  assign xdl = (PBits+1)'(px_s1) - $signed({1'b0, xb, FracBits'(0)});
  assign xdu = $signed({1'b0, xb1, FracBits'(0)}) - (PBits+1)'(px_s1);
  assign ydl = (PBits+1)'(py_s1) - $signed({1'b0, yb, FracBits'(0)});
  assign ydu = $signed({1'b0, yb1, FracBits'(0)}) - (PBits+1)'(py_s1);

  // bank b(i,j) holds x parity i, y parity j
  function automatic logic [QBits-1:0] baddr(input logic [ResBits-1:0] x0,
      input logic [ResBits-1:0] y0, input logic pi, input logic pj);
    logic [ResBits-1:0] x, y;
    x = (x0[0] == pi) ? x0 : x0 + 1'b1;
    y = (y0[0] == pj) ? y0 : y0 + 1'b1;
    return {x[ResBits-1:1], y[ResBits-1:1]};
  endfunction
  assign a0 = baddr(xb, yb, 1'b0, 1'b0);
  assign a1 = baddr(xb, yb, 1'b0, 1'b1);
  assign a2 = baddr(xb, yb, 1'b1, 1'b0);
  assign a3 = baddr(xb, yb, 1'b1, 1'b1);

  always_ff @(posedge clk) begin
    if (wsel && !wx[0] && !wy[0]) bank0[waddr] <= wr.data;
    if (wsel && !wx[0] &&  wy[0]) bank1[waddr] <= wr.data;
    if (wsel &&  wx[0] && !wy[0]) bank2[waddr] <= wr.data;
    if (wsel &&  wx[0] &&  wy[0]) bank3[waddr] <= wr.data;
    if (en) begin
      q0 <= bank0[a0];
      q1 <= bank1[a1];
      q2 <= bank2[a2];
      q3 <= bank3[a3];
      par_s2 <= {xb[0], yb[0]};
      xdl_s2 <= xdl; xdu_s2 <= xdu; ydl_s2 <= ydl; ydu_s2 <= ydu;
    end
  end

  // corner select by parity
  val_t w00, w10, w01, w11;
  always_comb begin
    unique case (par_s2)
      2'b00: begin w00 = q0; w01 = q1; w10 = q2; w11 = q3; end
      2'b01: begin w00 = q1; w01 = q0; w10 = q3; w11 = q2; end
      2'b10: begin w00 = q2; w01 = q3; w10 = q0; w11 = q1; end
      default: begin w00 = q3; w01 = q2; w10 = q1; w11 = q0; end
    endcase
  end

  // stage 3: x products, rounded
  localparam int MBits = 16 + PBits + 1;
  localparam int RBits = MBits - FracBits + 1;
  function automatic logic signed [RBits-1:0] rnd_m(input logic signed [MBits-1:0] v);
    logic signed [MBits:0] u;
    u = (MBits+1)'(v) + (MBits+1)'(1 << (FracBits-1));
    return RBits'(u >>> FracBits);
  endfunction
  logic signed [RBits-1:0] t00, t10, t01, t11;
  logic signed [PBits:0] ydl_s3, ydu_s3;
  always_ff @(posedge clk) begin
    if (en) begin
      t00 <= rnd_m(MBits'(w00) * MBits'(xdu_s2));
      t10 <= rnd_m(MBits'(w10) * MBits'(xdl_s2));
      t01 <= rnd_m(MBits'(w01) * MBits'(xdu_s2));
      t11 <= rnd_m(MBits'(w11) * MBits'(xdl_s2));
      ydl_s3 <= ydl_s2;
      ydu_s3 <= ydu_s2;
    end
  end

  // stage 4: y products and sum
  localparam int SBits = RBits + PBits + 3;
  logic signed [SBits-1:0] s_s4;
  always_ff @(posedge clk) begin
    if (en)
      s_s4 <= SBits'(t00 + t10) * SBits'(ydu_s3) + SBits'(t01 + t11) * SBits'(ydl_s3);
  end

  logic signed [SBits:0] su;
  logic signed [SBits-FracBits:0] r;
  assign su  = (SBits+1)'(s_s4) + (SBits+1)'(1 << (FracBits-1));
  assign r   = (SBits-FracBits+1)'(su >>> FracBits);
  assign sat = (r > 32767) || (r < -32768);
  assign res = (r > 32767) ? 16'sh7fff : (r < -32768) ? -16'sh8000 : val_t'(r);
endmodule

// ===== rtl/blte_merge.sv =====
// Merge stage: carries item tags and saturation flags through the unit pipeline.
module blte_merge
  import blte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  tag_t tag_in,
  input  logic sat_in,
  output tag_t tag_out
);
  localparam int Depth = 4;
  tag_t pipe [Depth];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) pipe[i] <= '0;
    end else if (en) begin
      pipe[0] <= tag_in;
      for (int i = 1; i < Depth; i++) pipe[i] <= pipe[i-1];
    end
  end
  always_comb begin
    tag_out = pipe[Depth-1];
    tag_out.sat = pipe[Depth-1].sat | (pipe[Depth-1].eval & sat_in);
  end
endmodule

// ===== rtl/bilinear_lookup_tree_eval_top.sv =====
// Top level: tree of bilinear lookup units, one layer of parallel lanes per tree level.
// Pipeline: 4 stages per tree layer, 2 layers at Dim=4, plus the output register; the first
// stage loads on the accepting edge.
// Throughput: one item per cycle; the whole pipeline advances when the output is free.
// Writes ride the item pipeline and land in each layer's tables as they reach that layer.
// rst (synchronous, active high) clears valid flags and sets grid_res to 10; tables not cleared.
module bilinear_lookup_tree_eval_top
  import blte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [10:0] entry_index,
  input  val_t        entry_value,
  input  val_t        in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7,
  output logic        out_valid,
  input  logic        out_ready,
  output val_t        root_value,
  output logic        saturated,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data
);
  logic [4:0] grid_res;
  logic [4:0] r1;
  logic       en;
  logic       acc;
  wr_t        wr;
  val_t       ins [NumIn];

  always_ff @(posedge clk) begin
    if (rst) grid_res <= 5'd10;
    else if (cfg_we) grid_res <= cfg_data;
  end
  // clamp to 2..MaxRes
  assign r1 = (grid_res < 5'd2) ? 5'd1 :
              (grid_res > 5'(MaxRes)) ? 5'(MaxRes - 1) : grid_res - 5'd1;

  // pipeline stalls only when the output register holds an untaken item
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign acc      = in_valid && in_ready;
  assign wr.en    = acc && (opcode == OP_WRITE) && (entry_index < IdxBits'(TableWords));
  assign wr.idx   = entry_index - IdxBits'(0);
  assign wr.data  = entry_value;
  assign ins = '{in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7};

  // layer values and tags
  val_t lv   [NumLayers+1][TreeWidth];
  tag_t tg   [NumLayers+1];
  logic [TreeWidth-1:0] usat [NumLayers];

  for (genvar i = 0; i < TreeWidth; i++) begin : g_leaf
    assign lv[0][i] = (i < Dim) ? ins[i] : '0;
  end
  assign tg[0] = '{vld: acc, eval: opcode == OP_EVAL, sat: 1'b0, wr: wr};

  for (genvar l = 0; l < NumLayers; l++) begin : g_layer
    localparam int W    = TreeWidth >> (l + 1);
    localparam int Base = TreeWidth - (TreeWidth >> l);
    for (genvar i = 0; i < TreeWidth; i++) begin : g_lane
      if (i < W) begin : g_u
        // each layer takes the write when it reaches that layer, keeping item order
        blte_unit u_unit (
          .clk(clk), .en(en), .base(IdxBits'((Base + i) * UnitWords)),
          .wr(tg[l].wr), .r1(r1),
          .xv(lv[l][2*i]), .yv(lv[l][2*i+1]),
          .res(lv[l+1][i]), .sat(usat[l][i])
        );
      end else begin : g_pad
        assign lv[l+1][i] = '0;
        assign usat[l][i] = 1'b0;
      end
    end
    blte_merge u_merge (
      .clk(clk), .rst(rst), .en(en), .tag_in(tg[l]),
      .sat_in(|usat[l]), .tag_out(tg[l+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= tg[NumLayers].vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      root_value <= tg[NumLayers].eval ? lv[NumLayers][0] : '0;
      saturated  <= tg[NumLayers].eval & tg[NumLayers].sat;
    end
  end
endmodule

// ===== rtl/blte_checker.sv =====
// Port-level checker for the lookup tree evaluator, bound to the top level.
module blte_checker
  import blte_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input val_t root_value,
  input logic saturated
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root_value) && $stable(saturated))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("not ready with empty output");
  a_ready_follow: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready)) else $error("ready does not follow output");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind bilinear_lookup_tree_eval_top blte_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .root_value(root_value), .saturated(saturated)
);

// ===== tb/bilinear_lookup_tree_eval_top_test.sv =====
// Self-checking testbench for the bilinear lookup tree evaluator top level.
`timescale 1ns / 100ps

module bilinear_lookup_tree_eval_top_test;
  import blte_pkg::*;

  // One input item as the sender sees it.
  typedef struct {
    logic             op;
    logic [10:0]      idx;
    val_t             wval;
    val_t             ins [NumIn];
  } lut_item_t;

  // One predicted root result.
  typedef struct {
    val_t root;
    logic sat;
  } root_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = OP_WRITE;
  logic [10:0] entry_index = '0;
  val_t        entry_value = '0;
  val_t        in_0 = '0, in_1 = '0, in_2 = '0, in_3 = '0;
  val_t        in_4 = '0, in_5 = '0, in_6 = '0, in_7 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  val_t        root_value;
  logic        saturated;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = '0;

  bilinear_lookup_tree_eval_top uut (
    .clk, .rst, .in_valid, .in_ready, .opcode, .entry_index, .entry_value,
    .in_0, .in_1, .in_2, .in_3, .in_4, .in_5, .in_6, .in_7,
    .out_valid, .out_ready, .root_value, .saturated, .cfg_we, .cfg_data
  );

  always #5 clk = ~clk;

  // Shadow copies of the block's state.
  shortint     weight_shadow [TableWords];
  logic [4:0]  grid_shadow = 5'd10;

  lut_item_t   pending_items [$];
  root_res_t   expected_roots [$];
  int          error_count = 0;

  // Receiver stall control, retuned per phase.
  bit          stall_on = 1'b0;
  logic [15:0] stall_pattern = 16'hffff;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  // Round to nearest, ties up: floor((v + half) / 2^F).
  function automatic longint round_frac(longint v);
    return (v + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
  endfunction

  function automatic longint lookup_unit(int unit, longint xv, longint yv, longint r1,
                                         inout bit sat);
    longint one_q, px, py, xb, yb, xdl, xdu, ydl, ydu, acc, r;
    longint w00, w10, w01, w11;
    int base;
    one_q = longint'(1) <<< FracBits;
    px = xv * r1;
    py = yv * r1;
    // cell index: truncate, clamp to 0..r1-1 (outside [0,1] extrapolates)
    xb = (px < 0) ? 0 : (px >>> FracBits);
    yb = (py < 0) ? 0 : (py >>> FracBits);
    if (xb > r1 - 1) xb = r1 - 1;
    if (yb > r1 - 1) yb = r1 - 1;
    xdl = px - xb * one_q;
    xdu = (xb + 1) * one_q - px;
    ydl = py - yb * one_q;
    ydu = (yb + 1) * one_q - py;
    base = unit * UnitWords;
    w00 = weight_shadow[base + int'(xb) * MaxRes + int'(yb)];
    w10 = weight_shadow[base + int'(xb + 1) * MaxRes + int'(yb)];
    w01 = weight_shadow[base + int'(xb) * MaxRes + int'(yb + 1)];
    w11 = weight_shadow[base + int'(xb + 1) * MaxRes + int'(yb + 1)];
    acc = round_frac(w00 * xdu) * ydu + round_frac(w10 * xdl) * ydu
        + round_frac(w01 * xdu) * ydl + round_frac(w11 * xdl) * ydl;
    r = round_frac(acc);
    if (r > 32767) begin
      r = 32767;
      sat = 1'b1;
    end
    if (r < -32768) begin
      r = -32768;
      sat = 1'b1;
    end
    return r;
  endfunction

  // Applies one accepted item to the shadow state and queues its result.
  function automatic void predict_root(lut_item_t it);
    root_res_t res;
    longint layer_vals [TreeWidth];
    longint r1;
    int width, unit;
    bit sat;
    res.root = '0;
    res.sat = 1'b0;
    if (it.op == OP_WRITE) begin
      // out-of-range index is dropped
      if (it.idx < TableWords) weight_shadow[it.idx] = it.wval;
    end else begin
      r1 = grid_shadow;
      if (r1 < 2) r1 = 2;
      if (r1 > MaxRes) r1 = MaxRes;
      r1 = r1 - 1;
      for (int i = 0; i < TreeWidth; i++)
        layer_vals[i] = (i < Dim) ? longint'(it.ins[i]) : 0;
      width = TreeWidth;
      unit = 0;
      sat = 1'b0;
      while (width > 1) begin
        for (int i = 0; i < width / 2; i++) begin
          layer_vals[i] = lookup_unit(unit, layer_vals[2*i], layer_vals[2*i+1], r1, sat);
          unit++;
        end
        width = width / 2;
      end
      res.root = val_t'(layer_vals[0]);
      res.sat = sat;
    end
    expected_roots.push_back(res);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------
  lut_item_t drv_item;
  int        burst_left = 1;
  int        gap_left = 0;

  always @(posedge clk) begin
    bit holding;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      holding = 1'b0;
      if (in_valid && in_ready) predict_root(drv_item);
      else holding = in_valid;
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drv_item = pending_items.pop_front();
          opcode <= drv_item.op;
          entry_index <= drv_item.idx;
          entry_value <= drv_item.wval;
          in_0 <= drv_item.ins[0];
          in_1 <= drv_item.ins[1];
          in_2 <= drv_item.ins[2];
          in_3 <= drv_item.ins[3];
          in_4 <= drv_item.ins[4];
          in_5 <= drv_item.ins[5];
          in_6 <= drv_item.ins[6];
          in_7 <= drv_item.ins[7];
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // about a third of the bursts run back to back
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: receiver stall pattern and result check
  // ---------------------------------------------------------------------
  int stall_phase = 0;

  always @(posedge clk) begin
    root_res_t exp_res;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 16;
      out_ready <= stall_on ? stall_pattern[stall_phase] : 1'b1;
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected item root_value=%0d saturated=%0b",
                   $time, root_value, saturated);
          error_count++;
        end else begin
          exp_res = expected_roots.pop_front();
          if (root_value !== exp_res.root) begin
            $display("%0t: root_value mismatch expected=%0d actual=%0d",
                     $time, exp_res.root, root_value);
            error_count++;
          end
          if (saturated !== exp_res.sat) begin
            $display("%0t: saturated mismatch expected=%0b actual=%0b",
                     $time, exp_res.sat, saturated);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic lut_item_t make_write(int idx, int wval);
    lut_item_t it;
    it.op = OP_WRITE;
    it.idx = idx[10:0];
    it.wval = val_t'(wval);
    for (int i = 0; i < NumIn; i++) it.ins[i] = val_t'($urandom);
    return it;
  endfunction

  function automatic lut_item_t make_eval(int a, int b, int c, int d);
    lut_item_t it;
    it.op = OP_EVAL;
    it.idx = 11'($urandom);
    it.wval = val_t'($urandom);
    // unused inputs carry noise; the block must ignore them
    for (int i = 0; i < NumIn; i++) it.ins[i] = val_t'($urandom);
    it.ins[0] = val_t'(a);
    it.ins[1] = val_t'(b);
    it.ins[2] = val_t'(c);
    it.ins[3] = val_t'(d);
    return it;
  endfunction

  // Mostly near the unit interval, sometimes anywhere in range.
  function automatic int rand_input();
    if ($urandom_range(0, 4) == 0) return int'(val_t'($urandom));
    return $urandom_range(0, 10240) - 2048;
  endfunction

  function automatic int rand_weight();
    if ($urandom_range(0, 9) == 0) return int'(val_t'($urandom));
    return $urandom_range(0, 8192) - 4096;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_roots.size() != 0);
    // drain margin: two layers plus output register
    repeat (16) @(negedge clk);
  endtask

  task automatic write_grid(logic [4:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    grid_shadow = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  logic [4:0] grid_steps [7] = '{5'd10, 5'd2, 5'd16, 5'd0, 5'd31, 5'd7, 5'd3};
  int edge_vals [8] = '{0, 4096, 32767, -32768, 2048, -1, 4095, -4096};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Load every table word first so no evaluation reads an unwritten one.
    for (int w = 0; w < TableWords; w++) begin
      if (w % 97 == 0) pending_items.push_back(make_write(w, 32767));
      else if (w % 89 == 0) pending_items.push_back(make_write(w, -32768));
      else pending_items.push_back(make_write(w, rand_weight()));
    end

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      write_grid(grid_steps[ph]);
      stall_on = (ph % 3) != 0;
      stall_pattern = 16'($urandom) | 16'h0101;

      if (ph == 0) begin
        // directed: field extremes, zero and one, dropped writes
        for (int k = 0; k < 8; k++)
          pending_items.push_back(make_eval(edge_vals[k], edge_vals[(k + 3) % 8],
                                            edge_vals[(k + 5) % 8], edge_vals[k]));
        pending_items.push_back(make_write(2047, -1));
        pending_items.push_back(make_write(TableWords, 1234));
        pending_items.push_back(make_write(0, 0));
        pending_items.push_back(make_eval(0, 0, 0, 0));
        pending_items.push_back(make_write(17, 32767));
        pending_items.push_back(make_eval(4096, 4096, 4096, 4096));
        pending_items.push_back(make_eval(-32768, -32768, 32767, 32767));
      end

      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 3) == 0)
            pending_items.push_back(make_write($urandom_range(TableWords, 2047),
                                               int'(val_t'($urandom))));
          else
            pending_items.push_back(make_write($urandom_range(0, TableWords - 1),
                                               rand_weight()));
        end else begin
          pending_items.push_back(make_eval(rand_input(), rand_input(),
                                            rand_input(), rand_input()));
        end
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("bilinear_lookup_tree_eval_top regression: pass");
    end else begin
      $display("bilinear_lookup_tree_eval_top regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("bilinear_lookup_tree_eval_top regression: fail");
    $finish;
  end

endmodule

// ===== bilinear_lookup_tree_eval_top.f =====
rtl/blte_pkg.sv
rtl/blte_unit.sv
rtl/blte_merge.sv
rtl/bilinear_lookup_tree_eval_top.sv
rtl/blte_checker.sv
tb/bilinear_lookup_tree_eval_top_test.sv
